### rtl/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// shared types and constants for the lzss ring buffer decoder
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int RING_AW    = 12;
    localparam int RING_SIZE  = 1 << RING_AW;
    localparam int MAX_MATCH  = 18;
    localparam int MIN_MATCH  = 3;
    localparam int CNT_W      = 24;
    localparam int REMAIN_W   = 5;

    localparam logic [RING_AW-1:0] RING_START = RING_AW'(RING_SIZE - MAX_MATCH);
    localparam logic [7:0]         SPACE_CHAR = 8'h20;

    // one compressed byte and its stream marks
    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_stream;
        logic       final_byte;
    } item_t;

    // one decoded byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       limit_reached;
    } result_t;

    // ring write port
    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic [7:0]         data;
    } ring_wr_t;

endpackage

### rtl/lzss_ring.sv
// ----------------------------------------------------------------------------
// lzss_ring
// 4096 x 8 history ring; entries not yet written since clear read as space
// ----------------------------------------------------------------------------
module lzss_ring (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  lzss_pkg::ring_wr_t            wr,
    input  logic                          rd_en,
    input  logic [lzss_pkg::RING_AW-1:0]  rd_addr,
    output logic [7:0]                    rd_data
);
    import lzss_pkg::*;

    logic [7:0]         mem [RING_SIZE];
    logic [7:0]         mem_q;
    logic               hit_reg;
    logic [RING_AW:0]   fill_reg;
    logic [RING_AW:0]   fill_next;
    logic [RING_AW-1:0] rd_offset;

    // writes run sequentially from the start position, so a fill count
    // tells which entries hold data
    assign rd_offset = rd_addr - RING_START;

    always_comb
    begin
        fill_next = fill_reg;
        if (clear)
        begin
            fill_next = '0;
        end
        else if (wr.en && (fill_reg != (RING_AW+1)'(RING_SIZE)))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q   <= mem[rd_addr];
            hit_reg <= ({1'b0, rd_offset} < fill_reg);
        end
    end

    assign rd_data = hit_reg ? mem_q : SPACE_CHAR;

endmodule

### rtl/lzss_ring_buffer_decoder_unit.sv
// ----------------------------------------------------------------------------
// lzss_ring_buffer_decoder_unit
// classic lzss decoder: 4096-byte history ring, matches of 3 to 18 bytes
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  payload
//  item      item_valid, item_ready, item     in         lzss_pkg::item_t
//  result    result_valid, result_ready, res  out        lzss_pkg::result_t
//  config    cfg_we, cfg_wdata                in         out_limit, 24 bit
//
//  steps: a flag byte or a pair low byte is taken in the idle state; a literal
//  goes on to the write step; a match copies each byte with a ring read step
//  followed by a ring write step through the single ring port pair.
//  reset: rst_n clears the control state and out_limit to its maximum; the
//  ring needs no clearing pass, a fill count makes unwritten entries read as
//  space. stalls: an untaken result holds the sequencer in its write step.
//
module lzss_ring_buffer_decoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  lzss_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output lzss_pkg::result_t           res,
    input  logic                        cfg_we,
    input  logic [lzss_pkg::CNT_W-1:0]  cfg_wdata
);
    import lzss_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_WR   = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    out_limit_reg;
    logic [8:0]          flags_reg, flags_next;
    logic [7:0]          low_reg, low_next;
    logic                await_reg, await_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                halted_reg, halted_next;
    logic [RING_AW-1:0]  wpos_reg, wpos_next;
    logic [RING_AW-1:0]  pos_reg, pos_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic                lit_mode_reg, lit_mode_next;
    logic [7:0]          lit_reg, lit_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic                accept;
    logic                slot_free;
    logic                halt_now;
    logic                emit;
    logic [CNT_W-1:0]    count_inc;
    logic [7:0]          cur_byte;
    logic [8:0]          flags_eff;
    logic                await_eff;
    logic                halted_eff;
    logic                ring_clear;
    ring_wr_t            ring_wr;
    logic                ring_rd_en;
    logic [7:0]          ring_rd_data;

    // drop the lowest flag; the marker alone means no flags pending
    function automatic logic [8:0] consume_flag(input logic [8:0] f);
        logic [8:0] s;
        s = f >> 1;
        return (s <= 9'd1) ? 9'd0 : s;
    endfunction

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = res_valid_reg;
    assign res          = res_reg;

    // a result slot frees when empty or when it is taken this cycle
    assign slot_free = !res_valid_reg || result_ready;
    assign halt_now  = (count_reg >= out_limit_reg);
    assign count_inc = count_reg + 1'b1;
    assign emit      = (state_reg == S_WR) && slot_free && !halt_now;
    assign cur_byte  = lit_mode_reg ? lit_reg : ring_rd_data;

    // start of stream restarts the decoder before the byte is used
    assign flags_eff  = item.start_of_stream ? 9'd0 : flags_reg;
    assign await_eff  = item.start_of_stream ? 1'b0 : await_reg;
    assign halted_eff = item.start_of_stream ? 1'b0 : halted_reg;
    assign ring_clear = accept && item.start_of_stream;

    always_comb
    begin
        state_next     = state_reg;
        flags_next     = flags_reg;
        low_next       = low_reg;
        await_next     = await_reg;
        count_next     = count_reg;
        halted_next    = halted_reg;
        wpos_next      = wpos_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        lit_mode_next  = lit_mode_reg;
        lit_next       = lit_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;
        ring_rd_en     = 1'b0;
        ring_wr.en     = 1'b0;
        ring_wr.addr   = wpos_reg;
        ring_wr.data   = cur_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.start_of_stream)
                    begin
                        flags_next  = '0;
                        low_next    = '0;
                        await_next  = 1'b0;
                        count_next  = '0;
                        halted_next = 1'b0;
                        wpos_next   = RING_START;
                    end
                    if (!halted_eff)
                    begin
                        if (await_eff)
                        begin
                            // pair high byte: launch the match copy
                            await_next    = 1'b0;
                            flags_next    = consume_flag(flags_eff);
                            pos_next      = {item.in_byte[7:4], low_reg};
                            remain_next   = REMAIN_W'(item.in_byte[3:0])
                                            + REMAIN_W'(MIN_MATCH);
                            lit_mode_next = 1'b0;
                            state_next    = S_RD;
                        end
                        else if (flags_eff <= 9'd1)
                        begin
                            flags_next = {1'b1, item.in_byte};
                        end
                        else if (flags_eff[0])
                        begin
                            flags_next    = consume_flag(flags_eff);
                            lit_next      = item.in_byte;
                            lit_mode_next = 1'b1;
                            remain_next   = REMAIN_W'(1);
                            state_next    = S_WR;
                        end
                        else
                        begin
                            low_next   = item.in_byte;
                            await_next = 1'b1;
                        end
                        // end of stream drops partial state and halts
                        if (item.final_byte)
                        begin
                            await_next  = 1'b0;
                            low_next    = '0;
                            flags_next  = '0;
                            halted_next = 1'b1;
                        end
                    end
                end
            end

            S_RD:
            begin
                ring_rd_en = 1'b1;
                pos_next   = pos_reg + 1'b1;
                state_next = S_WR;
            end

            S_WR:
            begin
                if (slot_free)
                begin
                    if (halt_now)
                    begin
                        // limit hit: drop the rest of the copy
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ring_wr.en             = 1'b1;
                        wpos_next              = wpos_reg + 1'b1;
                        count_next             = count_inc;
                        remain_next            = remain_reg - 1'b1;
                        res_valid_next         = 1'b1;
                        res_next.out_byte      = cur_byte;
                        res_next.limit_reached = (count_inc == out_limit_reg);
                        res_next.run_last      = (remain_reg == REMAIN_W'(1))
                                                 || (count_inc == out_limit_reg);
                        state_next = (remain_reg == REMAIN_W'(1)) ? S_IDLE : S_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_limit_reg <= {CNT_W{1'b1}};
            flags_reg     <= '0;
            low_reg       <= '0;
            await_reg     <= 1'b0;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            wpos_reg      <= RING_START;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flags_reg     <= flags_next;
            low_reg       <= low_next;
            await_reg     <= await_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            wpos_reg      <= wpos_next;
            remain_reg    <= remain_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                out_limit_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        lit_mode_reg <= lit_mode_next;
        lit_reg      <= lit_next;
        res_reg      <= res_next;
    end

    lzss_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (ring_clear),
        .wr      (ring_wr),
        .rd_en   (ring_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ring_rd_data)
    );

`ifndef SYNTHESIS
    // a copy in flight always has bytes left
    a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_WR) |-> (remain_reg != '0))
        else $error("sequencer busy with no bytes left");

    // an emitted byte shows up in the result register
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (result_valid && res.out_byte == $past(cur_byte)))
        else $error("emitted byte not presented");

    // the last byte of a copy returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && remain_reg == REMAIN_W'(1)) |=> (state_reg == S_IDLE && res.run_last))
        else $error("copy did not end on its last byte");

    // the flag marker never stands alone
    a_flags_marker: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg != 9'd1)
        else $error("empty flag word kept its marker");
`endif

endmodule

### bench/tb_lzss_ring_buffer_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_lzss_ring_buffer_decoder_unit
// self-checking bench: a directed script of compressed bytes, then random
// well-formed lzss streams with some noise, checked byte by byte against
// bytes typed in the script or a behavioral decoder kept inside the bench
// ----------------------------------------------------------------------------
module tb_lzss_ring_buffer_decoder_unit;

    import lzss_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    // margin over the longest item, a match of 18 bytes
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 380;
    localparam int MAX_PHASES    = 80;
    localparam int MAX_PRINTED   = 40;

    // how a script row states its outcome
    localparam int PREDICTED   = -1;   // decoder model decides
    localparam int TYPED_NONE  = 0;    // no decoded byte
    localparam int TYPED_ONE   = 1;    // exactly the byte typed in the row

    localparam logic [CNT_W-1:0] LIMIT_MAX = '1;

    typedef enum logic {
        ROW_ITEM,
        ROW_LIMIT
    } row_kind_e;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THREE_OF_FOUR,
        RX_LONG_STALL
    } rx_mode_e;

    typedef struct {
        row_kind_e        kind;
        item_t            it;
        logic [CNT_W-1:0] limit_val;
        int               typed_n;
        result_t          typed_res;
    } script_row_t;

    // dut ports, every input known from time zero
    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          res;
    logic             cfg_we       = 1'b0;
    logic [CNT_W-1:0] cfg_wdata    = '0;

    // decoder model state
    logic [7:0]         ring_model [RING_SIZE];
    logic [RING_AW-1:0] wr_pos;
    logic [8:0]         flag_bits;      // unused flags under a marker bit
    logic [7:0]         pair_low;
    logic               pair_pending;
    logic [CNT_W-1:0]   emitted;
    logic               halted;
    logic [CNT_W-1:0]   limit_model;

    // decoded bytes still owed by the dut, oldest first
    result_t expected_bytes[$];
    result_t want;

    int       errors      = 0;
    int       cycle_count = 0;
    int       burst_left  = 0;
    int       rx_left     = 0;
    rx_mode_e rx_mode     = RX_OPEN;
    logic [3:0] rx_phase  = '0;

    lzss_ring_buffer_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .res          (res),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------

    // new stream: ring back to spaces, write pointer near the top
    function automatic void restart_decoder();
        foreach (ring_model[i])
            ring_model[i] = SPACE_CHAR;
        wr_pos       = RING_START;
        flag_bits    = '0;
        pair_low     = '0;
        pair_pending = 1'b0;
        emitted      = '0;
        halted       = 1'b0;
    endfunction

    // shift out one flag; marker alone means the flag byte is used up
    function automatic void drop_flag();
        flag_bits = flag_bits >> 1;
        if (flag_bits <= 9'd1)
            flag_bits = '0;
    endfunction

    // one decoded byte, unless the output limit is already met
    function automatic bit ring_emit(input logic [7:0] c, ref result_t outq[$]);
        if (emitted >= limit_model) begin
            halted = 1'b1;
            return 1'b0;
        end
        emitted = emitted + 1'b1;
        outq.push_back('{out_byte: c, run_last: 1'b0,
                         limit_reached: (emitted == limit_model)});
        ring_model[wr_pos] = c;
        wr_pos = wr_pos + 1'b1;
        return 1'b1;
    endfunction

    // decode one compressed byte; nothing happens while halted
    task automatic decode_step(input item_t it, ref result_t outq[$]);
        logic [RING_AW-1:0] src;
        int                 len;
        if (it.start_of_stream)
            restart_decoder();
        if (halted)
            return;
        if (pair_pending) begin
            // high byte: position bits 11..8 on top, length minus 3 below
            src          = {it.in_byte[7:4], pair_low};
            len          = int'(it.in_byte[3:0]) + MIN_MATCH;
            pair_pending = 1'b0;
            drop_flag();
            // byte at a time, so an overlapping copy repeats its pattern
            for (int k = 0; k < len; k++)
                if (!ring_emit(ring_model[src + RING_AW'(k)], outq))
                    break;
        end
        else if (flag_bits <= 9'd1) begin
            flag_bits = {1'b1, it.in_byte};
        end
        else if (flag_bits[0]) begin
            drop_flag();
            void'(ring_emit(it.in_byte, outq));
        end
        else begin
            pair_low     = it.in_byte;
            pair_pending = 1'b1;
        end
        // stream end: half a pair and leftover flags are dropped
        if (it.final_byte) begin
            pair_pending = 1'b0;
            pair_low     = '0;
            flag_bits    = '0;
            halted       = 1'b1;
        end
        if (outq.size() > 0)
            outq[outq.size() - 1].run_last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // script rows
    // ------------------------------------------------------------------

    function automatic script_row_t step_row(input logic [7:0] b, input int sos,
                                             input int fin, input int tn,
                                             input logic [7:0] ob, input int lim);
        script_row_t r;
        r.kind      = ROW_ITEM;
        r.it        = '{in_byte: b, start_of_stream: (sos != 0), final_byte: (fin != 0)};
        r.limit_val = '0;
        r.typed_n   = tn;
        r.typed_res = '{out_byte: ob, run_last: 1'b1, limit_reached: (lim != 0)};
        return r;
    endfunction

    function automatic script_row_t limit_row(input int v);
        script_row_t r;
        r.kind      = ROW_LIMIT;
        r.it        = '0;
        r.limit_val = CNT_W'(v);
        r.typed_n   = TYPED_NONE;
        r.typed_res = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // one transaction on the item channel; bursts with random gaps between
    task automatic push_item(input item_t it, input int typed_n, input result_t typed_res);
        result_t step_q[$];
        if (burst_left == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 12);
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        // accepted at this edge
        decode_step(it, step_q);
        if (typed_n == PREDICTED) begin
            foreach (step_q[i])
                expected_bytes.push_back(step_q[i]);
        end
        else if (typed_n == TYPED_ONE) begin
            expected_bytes.push_back(typed_res);
        end
    endtask

    // hold the sender until every owed byte is out, then idle some more
    task automatic settle(input int extra);
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // out_limit only changes while the block is idle
    task automatic write_limit(input logic [CNT_W-1:0] v);
        settle(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        limit_model  = v;
    endtask

    // ------------------------------------------------------------------
    // receiver side and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (errors < MAX_PRINTED)
            $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, exp_val);
        errors++;
    endtask

    // result_ready follows a stall pattern that is picked anew at random intervals
    always @(posedge clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 80);
        end
        else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:          result_ready <= 1'b1;
            RX_COIN:          result_ready <= 1'($urandom_range(0, 1));
            RX_THREE_OF_FOUR: result_ready <= (rx_phase[1:0] != 2'd0);
            default:          result_ready <= (rx_phase >= 4'd11);
        endcase
    end

    // every result transaction against the oldest owed byte
    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("byte with none pending", int'(res.out_byte), 0);
            end
            else begin
                want = expected_bytes.pop_front();
                if (res.out_byte !== want.out_byte)
                    report_mismatch("out_byte", int'(res.out_byte), int'(want.out_byte));
                if (res.run_last !== want.run_last)
                    report_mismatch("run_last", int'(res.run_last), int'(want.run_last));
                if (res.limit_reached !== want.limit_reached)
                    report_mismatch("limit_reached", int'(res.limit_reached),
                                    int'(want.limit_reached));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_lzss_ring_buffer_decoder_unit: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        script_row_t        script[$];
        item_t              stream_q[$];
        item_t              next_it;
        logic [7:0]         flag_byte;
        logic [3:0]         mlen;
        logic [RING_AW-1:0] src;
        logic [RING_AW-1:0] gen_wp;
        logic [CNT_W-1:0]   new_limit;
        bit                 restart;
        int                 n_groups;
        int                 random_done;

        restart_decoder();
        limit_model = LIMIT_MAX;
        random_done = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, limit at its reset maximum
        // flag 0xfa: pair, literal, pair, then five literals
        script.push_back(step_row(8'hFA, 1, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'h00, 0, 0, TYPED_NONE, 8'h00, 0));
        // match from position 0: three spaces of the fresh ring
        script.push_back(step_row(8'h00, 0, 0, PREDICTED,  8'h00, 0));
        script.push_back(step_row(8'hFF, 0, 0, TYPED_ONE,  8'hFF, 0));
        // longest match overlapping its own output: 0xff repeated
        script.push_back(step_row(8'hF1, 0, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'hFF, 0, 0, PREDICTED,  8'h00, 0));
        script.push_back(step_row(8'h00, 0, 0, TYPED_ONE,  8'h00, 0));
        script.push_back(step_row(8'h80, 0, 0, TYPED_ONE,  8'h80, 0));
        script.push_back(step_row(8'h7F, 0, 0, TYPED_ONE,  8'h7F, 0));
        script.push_back(step_row(8'h55, 0, 0, TYPED_ONE,  8'h55, 0));
        script.push_back(step_row(8'hAA, 0, 0, TYPED_ONE,  8'hAA, 0));
        // all-pairs flag; first match reads across the ring wrap
        script.push_back(step_row(8'h00, 0, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'hFF, 0, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'hF0, 0, 0, PREDICTED,  8'h00, 0));
        // stream ends on half a pair, then a byte while halted
        script.push_back(step_row(8'h34, 0, 1, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'h41, 0, 0, TYPED_NONE, 8'h00, 0));
        // limit of two: second literal hits it, third is cut
        script.push_back(limit_row(2));
        script.push_back(step_row(8'hFF, 1, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'h31, 0, 0, TYPED_ONE,  8'h31, 0));
        script.push_back(step_row(8'h32, 0, 0, TYPED_ONE,  8'h32, 1));
        script.push_back(step_row(8'h33, 0, 1, TYPED_NONE, 8'h00, 0));
        // zero limit: the first match emits nothing
        script.push_back(limit_row(0));
        script.push_back(step_row(8'h00, 1, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'h00, 0, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'h05, 0, 0, TYPED_NONE, 8'h00, 0));
        // limit of five cuts an 18-byte match short
        script.push_back(limit_row(5));
        script.push_back(step_row(8'hFE, 1, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'h00, 0, 0, TYPED_NONE, 8'h00, 0));
        script.push_back(step_row(8'h0F, 0, 1, PREDICTED,  8'h00, 0));

        foreach (script[i]) begin
            if (script[i].kind == ROW_LIMIT)
                write_limit(script[i].limit_val);
            else
                push_item(script[i].it, script[i].typed_n, script[i].typed_res);
        end

        // random part: one run of groups per phase, each under a fresh limit
        gen_wp = RING_START;
        for (int phase = 0; phase < MAX_PHASES && random_done < RANDOM_ITEMS; phase++) begin
            case ($urandom_range(0, 9))
                0:       new_limit = '0;
                1:       new_limit = CNT_W'(1);
                2, 3:    new_limit = CNT_W'($urandom_range(1, 200));
                4:       new_limit = CNT_W'($urandom());
                default: new_limit = LIMIT_MAX;
            endcase
            write_limit(new_limit);

            // sometimes carry on the old stream, which may sit past a lowered limit
            restart = (phase == 0) || ($urandom_range(0, 3) != 0);
            if (restart)
                gen_wp = RING_START;

            // well-formed groups: flag byte, then its eight units
            stream_q.delete();
            n_groups = $urandom_range(1, 5);
            for (int g = 0; g < n_groups; g++) begin
                flag_byte = 8'($urandom());
                stream_q.push_back('{in_byte: flag_byte,
                                     start_of_stream: (restart && g == 0),
                                     final_byte: 1'b0});
                for (int b = 0; b < 8; b++) begin
                    if (flag_byte[b]) begin
                        stream_q.push_back('{in_byte: 8'($urandom()),
                                             start_of_stream: 1'b0, final_byte: 1'b0});
                        gen_wp = gen_wp + 1'b1;
                    end
                    else begin
                        // mostly close behind the write pointer, so real data comes back
                        if ($urandom_range(0, 3) != 0)
                            src = gen_wp - RING_AW'($urandom_range(1, 64));
                        else
                            src = RING_AW'($urandom());
                        mlen = 4'($urandom());
                        stream_q.push_back('{in_byte: src[7:0],
                                             start_of_stream: 1'b0, final_byte: 1'b0});
                        stream_q.push_back('{in_byte: {src[11:8], mlen},
                                             start_of_stream: 1'b0, final_byte: 1'b0});
                        gen_wp = gen_wp + RING_AW'(mlen) + RING_AW'(MIN_MATCH);
                    end
                end
            end

            // stream end: left open, cut one byte short, or closed cleanly
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    void'(stream_q.pop_back());
                    stream_q[stream_q.size() - 1].final_byte = 1'b1;
                end
                default: stream_q[stream_q.size() - 1].final_byte = 1'b1;
            endcase

            foreach (stream_q[j]) begin
                next_it = stream_q[j];
                // a little noise: restarts, stray bytes, early ends
                case ($urandom_range(0, 31))
                    0:       next_it.start_of_stream = 1'b1;
                    1:       next_it.in_byte = 8'($urandom());
                    2:       next_it.final_byte = 1'b1;
                    default: ;
                endcase
                // one mid-stream pause until the dut has caught up
                if (phase == 2 && j == stream_q.size() / 2)
                    settle(1);
                push_item(next_it, PREDICTED, '0);
                random_done++;
                if (random_done >= RANDOM_ITEMS)
                    break;
            end
        end

        settle(SETTLE_CYCLES + 12);
        if (errors == 0)
            $display("tb_lzss_ring_buffer_decoder_unit: done, clean");
        else
            $display("tb_lzss_ring_buffer_decoder_unit: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/lzss_pkg.sv
rtl/lzss_ring.sv
rtl/lzss_ring_buffer_decoder_unit.sv
bench/tb_lzss_ring_buffer_decoder_unit.sv
